// ===== hw/rtl/jsve_pkg.sv =====
// Constants, types and a helper function shared by the JSON string value extractor.
package jsve_pkg;

    // key storage: four 64-bit words, 32 bytes in all
    localparam int KEY_BYTES  = 32;
    localparam int KEY_IDX_W  = 5;
    localparam int KEY_WORDS  = 4;
    localparam int KEY_LEN_W  = 6;

    // characters of the pattern and of the value syntax
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // result kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // register map, index = byte address / 8
    localparam int         CFG_ADDR_W  = 6;
    localparam int         CFG_DATA_W  = 64;
    localparam logic [2:0] REG_KEY_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_W0  = 3'd1;
    localparam logic [2:0] REG_KEY_W1  = 3'd2;
    localparam logic [2:0] REG_KEY_W2  = 3'd3;
    localparam logic [2:0] REG_KEY_W3  = 3'd4;
    localparam logic [2:0] REG_CAP     = 3'd5;

    localparam int         CAP_W     = 9;
    localparam logic [8:0] CAP_MAX   = 9'd256;
    localparam logic [8:0] CAP_RESET = 9'd200;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] exp_byte;
        logic       care;
    } cell_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] key_byte(input logic [KEY_BYTES*8-1:0] words,
                                            input logic [KEY_IDX_W-1:0]   idx);
        return words[idx*8 +: 8];
    endfunction

endpackage

// ===== hw/rtl/jsve_stream_if.sv =====
// Stream interfaces for body bytes in and extraction results out.
interface jsve_body_if;
    import jsve_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       end_of_body;

    modport source (output valid, body_byte, end_of_body, input ready);
    modport sink   (input valid, body_byte, end_of_body, output ready);
endinterface

interface jsve_result_if;
    import jsve_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic       last;

    modport source (output valid, kind, value_byte, last, input ready);
    modport sink   (input valid, kind, value_byte, last, output ready);
endinterface

// ===== hw/rtl/jsve_cell.sv =====
// One window cell: holds a recent body byte, shifts it on, and checks it against its pattern byte.
module jsve_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                clear,
    input  jsve_pkg::cell_cfg_t cfg,
    input  logic [7:0]          din,
    output logic [7:0]          dout,
    output logic                hit
);
    import jsve_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (shift)
        begin
            byte_next = clear ? 8'd0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;
    // a position outside the pattern always passes
    assign hit  = !cfg.care || (byte_reg == cfg.exp_byte);

endmodule

// ===== hw/rtl/jsve_outq.sv =====
// Four-entry result queue that takes up to two results per cycle and hands out one.
module jsve_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jsve_pkg::push_t      push,
    output logic                 room,
    jsve_result_if.source        result
);
    import jsve_pkg::*;

    result_t               q_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   head_reg;
    logic [OQ_PTR_W-1:0]   head_next;
    logic [OQ_PTR_W-1:0]   tail_reg;
    logic [OQ_PTR_W-1:0]   tail_next;
    logic [OQ_CNT_W-1:0]   count_reg;
    logic [OQ_CNT_W-1:0]   count_next;
    logic                  pop;

    assign pop  = result.valid && result.ready;
    assign room = count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    always_comb
    begin
        head_next  = pop ? OQ_PTR_W'(head_reg + 1'b1) : head_reg;
        tail_next  = OQ_PTR_W'(tail_reg + push.cnt);
        count_next = OQ_CNT_W'(count_reg + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            q_mem[tail_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            q_mem[OQ_PTR_W'(tail_reg + 1'b1)] <= push.second;
        end
    end

    assign result.valid      = count_reg != '0;
    assign result.kind       = q_mem[head_reg].kind;
    assign result.value_byte = q_mem[head_reg].value_byte;
    assign result.last       = q_mem[head_reg].last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count beyond depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2)))
        else $error("result pushed without room");
`endif

endmodule

// ===== hw/rtl/json_string_value_extract.sv =====
// Top level of the streaming JSON string value extractor.
//
// The block takes one body byte per cycle and watches a window of the most
// recent bytes for quote, key, quote, colon, quote. The window is a row of
// MAX_KEY+3 cells that shift every accepted byte along and each compare their
// byte against the pattern byte for their position; the AND of the cell hits
// and a quote on the incoming byte marks the match, all in the cycle the byte
// arrives. After the first match the value bytes come out one result each,
// with backslash escapes removed, until an unescaped quote, the end of the
// body or value_capacity minus one bytes. The last byte of every body adds one
// finishing result (kind 1 value found, kind 2 none), and the final result of
// each byte carries last. Throughput: one body byte per cycle while the queue
// has room; results leave a four-entry queue at one per cycle while result
// ready is high; a byte giving a value byte and a finishing result pushes two.
// body ready is high while the queue has room for two results and does not
// depend on result ready. Results are queued in registers and leave in order.
// Registers sit on an APB port at byte address 8*index, 64-bit data; the key
// length and key bytes are folded into a registered effective length on every
// write so the window compare sees a settled pattern.
module json_string_value_extract #(
    parameter int MAX_KEY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    jsve_body_if.sink                         body,
    jsve_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jsve_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [jsve_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [jsve_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import jsve_pkg::*;

    localparam int DEPTH = MAX_KEY + 3;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [KEY_LEN_W-1:0]      key_len_reg;
    logic [KEY_LEN_W-1:0]      key_len_next;
    logic [KEY_BYTES*8-1:0]    key_reg;
    logic [KEY_BYTES*8-1:0]    key_next;
    logic [CAP_W-1:0]          cap_reg;
    logic [CAP_W-1:0]          cap_next;
    logic [KEY_LEN_W-1:0]      eff_len_reg;
    logic [KEY_LEN_W-1:0]      eff_len_next;
    logic [KEY_LEN_W-1:0]      len_clip;
    logic [2:0]                reg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        key_len_next = key_len_reg;
        key_next     = key_reg;
        cap_next     = cap_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_KEY_LEN: key_len_next = pwdata[KEY_LEN_W-1:0];
                REG_KEY_W0:  key_next[0*64 +: 64] = pwdata;
                REG_KEY_W1:  key_next[1*64 +: 64] = pwdata;
                REG_KEY_W2:  key_next[2*64 +: 64] = pwdata;
                REG_KEY_W3:  key_next[3*64 +: 64] = pwdata;
                REG_CAP:     cap_next = pwdata[CAP_W-1:0];
                default:     ;
            endcase
        end
    end

    // effective key length: clip to MAX_KEY and to the stored bytes, then
    // stop at the first zero key byte
    always_comb
    begin
        len_clip = (key_len_next > KEY_LEN_W'(MAX_KEY)) ? KEY_LEN_W'(MAX_KEY) : key_len_next;
        if (len_clip > KEY_LEN_W'(KEY_BYTES))
        begin
            len_clip = KEY_LEN_W'(KEY_BYTES);
        end
        eff_len_next = len_clip;
        for (int i = KEY_BYTES - 1; i >= 0; i--)
        begin
            if ((KEY_LEN_W'(i) < len_clip) && (key_byte(key_next, KEY_IDX_W'(i)) == 8'd0))
            begin
                eff_len_next = KEY_LEN_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= '0;
            key_reg     <= '0;
            cap_reg     <= CAP_RESET;
            eff_len_reg <= '0;
        end
        else
        begin
            key_len_reg <= key_len_next;
            key_reg     <= key_next;
            cap_reg     <= cap_next;
            eff_len_reg <= eff_len_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_LEN: prdata = CFG_DATA_W'(key_len_reg);
            REG_KEY_W0:  prdata = key_reg[0*64 +: 64];
            REG_KEY_W1:  prdata = key_reg[1*64 +: 64];
            REG_KEY_W2:  prdata = key_reg[2*64 +: 64];
            REG_KEY_W3:  prdata = key_reg[3*64 +: 64];
            REG_CAP:     prdata = CFG_DATA_W'(cap_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // window of recent bytes: cell j holds the byte j+1 back
    // ---------------------------------------------------------------
    logic               accept;
    logic               body_end;
    logic [7:0]         win [DEPTH];
    logic [DEPTH-1:0]   hit;
    cell_cfg_t          cell_cfg [DEPTH];
    logic [6:0]         len_ext;
    logic               match_now;

    assign accept   = body.valid && body.ready;
    assign body_end = body.end_of_body;
    assign len_ext  = {1'b0, eff_len_reg};

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        localparam logic [6:0] JJ = 7'(j);
        logic [7:0] din;

        // pattern read backward: colon, quote, key reversed, quote
        always_comb
        begin
            cell_cfg[j].care     = 1'b1;
            cell_cfg[j].exp_byte = CH_QUOTE;
            if (JJ == 7'd0)
            begin
                cell_cfg[j].exp_byte = CH_COLON;
            end
            else if (JJ == 7'd1)
            begin
                cell_cfg[j].exp_byte = CH_QUOTE;
            end
            else if (JJ <= 7'(len_ext + 7'd1))
            begin
                cell_cfg[j].exp_byte = key_byte(key_reg, KEY_IDX_W'(len_ext + 7'd1 - JJ));
            end
            else if (JJ == 7'(len_ext + 7'd2))
            begin
                cell_cfg[j].exp_byte = CH_QUOTE;
            end
            else
            begin
                cell_cfg[j].care = 1'b0;
            end
        end

        if (j == 0)
        begin : g_head
            assign din = body.body_byte;
        end
        else
        begin : g_link
            assign din = win[j-1];
        end

        jsve_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .clear (body_end),
            .cfg   (cell_cfg[j]),
            .din   (din),
            .dout  (win[j]),
            .hit   (hit[j])
        );
    end

    assign match_now = (body.body_byte == CH_QUOTE) && (&hit);

    // ---------------------------------------------------------------
    // value extraction
    // ---------------------------------------------------------------
    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic           esc_reg;
    logic           esc_next;
    logic [7:0]     cnt_reg;
    logic [7:0]     cnt_next;
    logic [7:0]     cnt_inc;
    logic [CAP_W-1:0] cap_lim;
    logic           emit;
    logic [1:0]     fin_kind;
    push_t          push;
    logic           q_room;

    assign cap_lim = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign cnt_inc = 8'(cnt_reg + 8'd1);

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (match_now)
                begin
                    phase_next = (cap_lim > 9'd1) ? PH_VALUE : PH_DONE;
                end
            end
            PH_VALUE:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    emit     = 1'b1;
                end
                else if (body.body_byte == CH_QUOTE)
                begin
                    phase_next = PH_DONE;
                end
                else if ((body.body_byte == CH_BACKSLASH) && !body_end)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
                if (emit)
                begin
                    cnt_next = cnt_inc;
                    // stop one short of the buffer size
                    if (CAP_W'({1'b0, cnt_inc} + 9'd1) >= cap_lim)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        fin_kind = (cnt_next != 8'd0) ? KIND_FOUND : KIND_NONE;

        // end of body: drop all body state back to search
        if (body_end)
        begin
            phase_next = PH_SEARCH;
            esc_next   = 1'b0;
            cnt_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            esc_reg   <= 1'b0;
            cnt_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // results of this transfer: an optional value byte, then the finisher at end of body
    always_comb
    begin
        push.cnt               = accept ? 2'(2'(emit) + 2'(body_end)) : 2'd0;
        push.second.kind       = fin_kind;
        push.second.value_byte = 8'd0;
        push.second.last       = 1'b1;
        if (emit)
        begin
            push.first.kind       = KIND_VALUE;
            push.first.value_byte = body.body_byte;
            push.first.last       = !body_end;
        end
        else
        begin
            push.first = push.second;
        end
    end

    jsve_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (q_room),
        .result (result)
    );

    // take a byte only while two results still fit
    assign body.ready = q_room;

`ifndef SYNTHESIS
    a_esc_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg == PH_VALUE))
        else $error("escape pending outside a value");

    a_search_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |-> (cnt_reg == 8'd0))
        else $error("value count held while searching");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && body_end) |=> (phase_reg == PH_SEARCH && !esc_reg && win[0] == 8'd0))
        else $error("body state not cleared after end of body");
`endif

endmodule
